// ===== rtl/core/ws2812_pkg.sv =====
// Shared types, codes and constants of the LED bit-duty serializer.
package ws2812_pkg;

    localparam int MAX_LEDS      = 256;
    localparam int LED_IDX_W     = $clog2(MAX_LEDS);
    localparam int LED_CNT_W     = 9;
    localparam int DUTY_W        = 10;
    localparam int COLOR_W       = 24;
    localparam int BITS_PER_LED  = COLOR_W;
    localparam int BIT_POS_W     = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 10;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [LED_CNT_W-1:0] LED_COUNT_RST = 9'd2;
    localparam logic [DUTY_W-1:0]    HIGH_DUTY_RST = 10'd60;
    localparam logic [DUTY_W-1:0]    LOW_DUTY_RST  = 10'd30;

    // Operation codes of a request.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_DUTY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_DUTY  = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [LED_IDX_W-1:0] led_number;
        logic [COLOR_W-1:0]   color_word;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              busy_res;
        logic              frame_done;
        logic              start_rejected;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [LED_IDX_W-1:0] led;
        logic [COLOR_W-1:0]   word;
    } cmd_t;

endpackage

// ===== rtl/core/ws2812_fifo.sv =====
// Small first-in first-out queue built from registers.
module ws2812_fifo
    import ws2812_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/ws2812_front.sv =====
// Front end: accepts requests, decodes them into commands and queues them.
module ws2812_front
    import ws2812_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t request,
    output logic     full,
    input  logic     cmd_pop,
    output cmd_t     cmd,
    output logic     cmd_empty
);

    cmd_t                cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        cmd_in.led  = request.led_number;
        cmd_in.word = request.color_word;
        case (request.operation)
            OP_WRITE: cmd_in.kind = CMD_WRITE;
            OP_START: cmd_in.kind = CMD_START;
            OP_TICK:  cmd_in.kind = CMD_TICK;
            default:  cmd_in.kind = CMD_NOP;
        endcase
    end

    ws2812_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QDEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

// ===== rtl/core/ws2812_back.sv =====
// Back end: color store, frame sequencer, configuration and duty selection.
module ws2812_back
    import ws2812_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic                   cmd_empty,
    output logic                   cmd_pop,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   cfg_ready,
    output out_item_t              res,
    output logic                   res_push,
    input  logic                   res_full
);

    typedef struct packed {
        logic                 has_bit;
        logic [BIT_POS_W-1:0] bit_index;
        logic                 busy;
        logic                 done;
        logic                 rejected;
    } stage_info_t;

    localparam logic [BIT_POS_W-1:0] LAST_POS = BIT_POS_W'(BITS_PER_LED - 1);

    logic [COLOR_W-1:0]   color_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0]  written_reg;

    logic [LED_CNT_W-1:0] led_count_reg;
    logic [DUTY_W-1:0]    high_duty_reg;
    logic [DUTY_W-1:0]    low_duty_reg;

    logic                 sending_reg, sending_next;
    logic [LED_IDX_W-1:0] cur_led_reg, cur_led_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;

    logic                 b_valid_reg, b_valid_next;
    stage_info_t          info_reg;
    stage_info_t          info;
    logic [COLOR_W-1:0]   rd_data_reg;
    logic                 rd_written_reg;

    logic                 a_fire;
    logic                 b_go;
    logic                 mem_we;
    logic [LED_CNT_W-1:0] frame_len;
    logic [LED_CNT_W-1:0] next_led_cnt;
    logic [BIT_POS_W-1:0] pos_eff;
    logic [COLOR_W-1:0]   color;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RST;
            high_duty_reg <= HIGH_DUTY_RST;
            low_duty_reg  <= LOW_DUTY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LED_COUNT: led_count_reg <= cfg_data[LED_CNT_W-1:0];
                CFG_HIGH_DUTY: high_duty_reg <= cfg_data[DUTY_W-1:0];
                CFG_LOW_DUTY:  low_duty_reg  <= cfg_data[DUTY_W-1:0];
                default:       ;
            endcase
        end
    end

    // A command leaves the queue when the read stage is free or draining.
    assign b_go    = b_valid_reg && !res_full;
    assign a_fire  = !cmd_empty && (!b_valid_reg || b_go);
    assign cmd_pop = a_fire;

    // Frame length clamped to one through the store depth.
    always_comb
    begin
        if (led_count_reg == '0)
        begin
            frame_len = LED_CNT_W'(1);
        end
        else if (led_count_reg > LED_CNT_W'(MAX_LEDS))
        begin
            frame_len = LED_CNT_W'(MAX_LEDS);
        end
        else
        begin
            frame_len = led_count_reg;
        end
    end

    assign next_led_cnt = {1'b0, cur_led_reg} + 1'b1;
    assign pos_eff      = (bit_pos_reg > LAST_POS) ? LAST_POS : bit_pos_reg;

    always_comb
    begin
        sending_next   = sending_reg;
        cur_led_next   = cur_led_reg;
        bit_pos_next   = bit_pos_reg;
        mem_we         = 1'b0;
        info.has_bit   = 1'b0;
        info.bit_index = LAST_POS - pos_eff;
        info.done      = 1'b0;
        info.rejected  = 1'b0;
        case (cmd.kind)
            CMD_WRITE:
            begin
                mem_we = a_fire;
            end
            CMD_START:
            begin
                if (sending_reg)
                begin
                    info.rejected = 1'b1;
                end
                else
                begin
                    sending_next = 1'b1;
                    cur_led_next = '0;
                    bit_pos_next = '0;
                end
            end
            CMD_TICK:
            begin
                if (sending_reg)
                begin
                    info.has_bit = 1'b1;
                    if (pos_eff == LAST_POS)
                    begin
                        bit_pos_next = '0;
                        if (next_led_cnt >= frame_len)
                        begin
                            sending_next = 1'b0;
                            cur_led_next = '0;
                            info.done    = 1'b1;
                        end
                        else
                        begin
                            cur_led_next = next_led_cnt[LED_IDX_W-1:0];
                        end
                    end
                    else
                    begin
                        bit_pos_next = pos_eff + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        info.busy = sending_next;
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (a_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_go)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            cur_led_reg <= '0;
            bit_pos_reg <= '0;
            b_valid_reg <= 1'b0;
            written_reg <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            if (a_fire)
            begin
                sending_reg <= sending_next;
                cur_led_reg <= cur_led_next;
                bit_pos_reg <= bit_pos_next;
            end
            if (mem_we)
            begin
                written_reg[cmd.led] <= 1'b1;
            end
        end
    end

    // The store is read at the LED in progress; an entry never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[cmd.led] <= cmd.word;
        end
        if (a_fire)
        begin
            rd_data_reg    <= color_mem[cur_led_reg];
            rd_written_reg <= written_reg[cur_led_reg];
            info_reg       <= info;
        end
    end

    assign color = rd_written_reg ? rd_data_reg : '0;

    always_comb
    begin
        res.busy_res       = info_reg.busy;
        res.frame_done     = info_reg.done;
        res.start_rejected = info_reg.rejected;
        if (!info_reg.has_bit)
        begin
            res.duty = '0;
        end
        else if (color[info_reg.bit_index])
        begin
            res.duty = high_duty_reg;
        end
        else
        begin
            res.duty = low_duty_reg;
        end
    end

    assign res_push = b_go;

endmodule

// ===== rtl/core/ws2812_bit_duty_serializer_top.sv =====
// Top level of the LED bit-duty serializer.
//
// Requests enter through push/full: a write stores a 24-bit color for one LED,
// a start begins a frame, and each tick asks for the PWM compare value of the
// next bit of the frame. Every request yields exactly one result, taken in
// order through empty/pop; a tick outside a frame, a write and a start give
// duty zero. A start during a frame is flagged as rejected.
// Configuration (LED count, high and low duty) is written through cfg_valid/cfg_ready
// by the user only while idle, not enforced by the block; cfg_ready is always high.
// A request's result passes from the command queue through the registered read stage
// into the result queue, from which it is popped.
// While the receiver keeps popping, one request per cycle is sustained: the command
// queue, the color store (one write and one registered read a cycle) and the result
// queue each move one item per cycle.
// If the receiver stops popping, the result queue fills, the read stage holds,
// and full rises once the command queue also fills; nothing is dropped.
// Reset empties both queues, stops any frame, restores the configuration
// defaults and makes every stored color read as zero.
module ws2812_bit_duty_serializer_top
    import ws2812_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  in_item_t               request,
    output logic                   full,
    output logic                   empty,
    input  logic                   pop,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t                         cmd;
    logic                         cmd_empty;
    logic                         cmd_pop;
    out_item_t                    res;
    logic                         res_push;
    logic                         res_full;
    logic [$bits(out_item_t)-1:0] result_bits;

    ws2812_front #(
        .QDEPTH (QDEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    ws2812_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    ws2812_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QDEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result_bits),
        .empty   (empty)
    );

    assign result = out_item_t'(result_bits);

endmodule

// ===== tb/ws2812_bit_duty_serializer_top_tb.sv =====
// Self-checking testbench for the LED bit-duty serializer top level.
`timescale 1ns / 1ps

module ws2812_bit_duty_serializer_top_tb;
    import ws2812_pkg::*;

    localparam int RESULT_LATENCY = 3;
    localparam int HOLD_CYCLES    = 80;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_CAP      = 100;
    localparam int PHASE_ITEMS    = 120;
    localparam int PHASES         = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    in_item_t               request = '0;
    logic                   full;
    logic                   empty;
    logic                   pop = 1'b0;
    out_item_t              result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    ws2812_bit_duty_serializer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the serializer state and its registers.
    logic [COLOR_W-1:0]   color_mem [MAX_LEDS];
    int unsigned          tx_led;
    int unsigned          tx_bit;
    bit                   tx_active;
    logic [LED_CNT_W-1:0] led_count_reg;
    logic [DUTY_W-1:0]    high_duty_reg;
    logic [DUTY_W-1:0]    low_duty_reg;

    out_item_t pending_duty_q [$];
    int        error_count = 0;
    int        sent_count = 0;
    int        cycle_count = 0;
    bit        steady_mode = 1'b0;
    int        hold_trigger = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned frame_leds();
        int unsigned n;
        n = 32'(led_count_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_LEDS)
            n = MAX_LEDS;
        return n;
    endfunction

    function automatic out_item_t next_duty_result(input in_item_t req);
        out_item_t          r;
        logic [COLOR_W-1:0] color;
        r = '0;
        case (cmd_kind_t'(req.operation))
            CMD_WRITE:
            begin
                color_mem[req.led_number] = req.color_word;
            end
            CMD_START:
            begin
                if (tx_active)
                    r.start_rejected = 1'b1;
                else
                begin
                    tx_active = 1'b1;
                    tx_led = 0;
                    tx_bit = 0;
                end
            end
            CMD_TICK:
            begin
                if (tx_active)
                begin
                    color = color_mem[LED_IDX_W'(tx_led)];
                    r.duty = color[BIT_POS_W'(BITS_PER_LED - 1 - tx_bit)] ? high_duty_reg
                                                                          : low_duty_reg;
                    if (tx_bit >= BITS_PER_LED - 1)
                    begin
                        tx_bit = 0;
                        if (tx_led + 1 >= frame_leds())
                        begin
                            tx_active = 1'b0;
                            tx_led = 0;
                            r.frame_done = 1'b1;
                        end
                        else
                            tx_led = tx_led + 1;
                    end
                    else
                        tx_bit = tx_bit + 1;
                end
            end
            default: ;
        endcase
        r.busy_res = tx_active;
        return r;
    endfunction

    function automatic in_item_t make_req(input cmd_kind_t op, input int unsigned led,
                                          input logic [COLOR_W-1:0] word);
        in_item_t r;
        r.operation  = op;
        r.led_number = led[LED_IDX_W-1:0];
        r.color_word = word;
        return r;
    endfunction

    function automatic in_item_t random_req();
        in_item_t r;
        r.operation  = 2'($urandom_range(0, 3));
        r.led_number = LED_IDX_W'($urandom);
        r.color_word = COLOR_W'($urandom);
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Pushes one request, leaving push high so that back-to-back requests keep it up.
    task automatic send_request(input in_item_t item);
        int gap;
        gap = 0;
        if (!steady_mode)
            while ($urandom_range(0, 99) < 13)
                gap++;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        request <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_duty_q.push_back(next_duty_result(item));
        sent_count++;
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (pending_duty_q.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LED_COUNT: led_count_reg = data[LED_CNT_W-1:0];
            CFG_HIGH_DUTY: high_duty_reg = data;
            CFG_LOW_DUTY:  low_duty_reg  = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Ticks until the running frame ends, mixing in stray requests now and then.
    task automatic tick_through_frame(input int noise_pct);
        while (tx_active)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_request(random_req());
            else
                send_request(make_req(CMD_TICK, 0, '0));
        end
    endtask

    task automatic test_idle_requests();
        send_request(make_req(CMD_TICK, 0, '0));
        send_request(make_req(CMD_NOP, 255, 24'hFFFFFF));
        send_request(make_req(CMD_WRITE, 255, 24'hFFFFFF));
        send_request(make_req(CMD_WRITE, 0, 24'h800001));
        send_request(make_req(CMD_WRITE, 1, 24'h000000));
        send_request(make_req(CMD_TICK, 0, 24'hFFFFFF));
        wait_for_results();
    endtask

    task automatic test_single_led_frame();
        // A zero LED count is clamped to a single LED.
        write_reg(CFG_LED_COUNT, 10'd0);
        write_reg(CFG_HIGH_DUTY, 10'd1023);
        write_reg(CFG_LOW_DUTY, 10'd0);
        send_request(make_req(CMD_START, 0, '0));
        send_request(make_req(CMD_START, 0, '0));
        repeat (10) send_request(make_req(CMD_TICK, 0, '0));
        // Overwriting the LED in progress changes its remaining bits.
        send_request(make_req(CMD_WRITE, 0, 24'h0F0F0F));
        tick_through_frame(0);
        send_request(make_req(CMD_TICK, 0, '0));
        wait_for_results();
    endtask

    task automatic test_mid_frame_changes();
        write_reg(CFG_LED_COUNT, 10'd2);
        write_reg(CFG_HIGH_DUTY, 10'd60);
        write_reg(CFG_LOW_DUTY, 10'd30);
        send_request(make_req(CMD_WRITE, 0, 24'hC3A55A));
        send_request(make_req(CMD_START, 0, '0));
        repeat (5) send_request(make_req(CMD_TICK, 0, '0));
        send_request(make_req(CMD_WRITE, 1, 24'h5AC3A5));
        tick_through_frame(0);
        wait_for_results();

        write_reg(CFG_LED_COUNT, 10'd4);
        send_request(make_req(CMD_START, 0, '0));
        repeat (30) send_request(make_req(CMD_TICK, 0, '0));
        send_request(make_req(CMD_WRITE, 2, COLOR_W'($urandom)));
        send_request(make_req(CMD_WRITE, 3, COLOR_W'($urandom)));
        repeat (25) send_request(make_req(CMD_TICK, 0, '0));
        wait_for_results();
        // The frame is inside LED 2; a count of 1 ends it after that LED.
        write_reg(CFG_LED_COUNT, 10'd1);
        tick_through_frame(0);
        send_request(make_req(CMD_TICK, 0, '0));
        wait_for_results();
    endtask

    task automatic test_long_frame();
        int i;
        for (i = 0; i < 8; i++)
            send_request(make_req(CMD_WRITE, $urandom_range(0, 7), COLOR_W'($urandom)));
        wait_for_results();
        write_reg(CFG_LED_COUNT, 10'd256);
        write_reg(CFG_HIGH_DUTY, 10'd512);
        write_reg(CFG_LOW_DUTY, 10'd1);
        send_request(make_req(CMD_START, 0, '0));
        repeat (50) send_request(make_req(CMD_TICK, 0, '0));
        wait_for_results();
        // All ones: the tenth bit is dropped, and 511 is clamped to the store size.
        write_reg(CFG_LED_COUNT, 10'h3FF);
        repeat (30) send_request(make_req(CMD_TICK, 0, '0));
        wait_for_results();
        // The frame is inside LED 3; a count of 4 ends it after that LED.
        write_reg(CFG_LED_COUNT, 10'd4);
        tick_through_frame(1);
        wait_for_results();
    endtask

    task automatic test_back_pressure();
        write_reg(CFG_LED_COUNT, 10'd2);
        steady_mode = 1'b1;
        hold_trigger++;
        send_request(make_req(CMD_START, 0, '0));
        repeat (40) send_request(make_req(CMD_TICK, 0, '0));
        steady_mode = 1'b0;
        wait_for_results();
        tick_through_frame(0);
        wait_for_results();
    endtask

    task automatic pick_random_config(input int phase);
        int unsigned pick;
        pick = $urandom_range(0, 5);
        write_reg(CFG_LED_COUNT, (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1
                                  : CFG_DATA_W'($urandom_range(2, 4)));
        pick = $urandom_range(0, 3);
        write_reg(CFG_HIGH_DUTY, (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023
                                  : CFG_DATA_W'($urandom));
        pick = $urandom_range(0, 3);
        write_reg(CFG_LOW_DUTY, (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023
                                 : CFG_DATA_W'($urandom));
        if (phase == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    task automatic test_random_frames();
        int phase;
        int phase_start;
        int unsigned nleds;
        int unsigned led;
        for (phase = 0; phase < PHASES; phase++)
        begin
            pick_random_config(phase);
            steady_mode = (phase == 3);
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    nleds = frame_leds();
                    repeat ($urandom_range(0, 3))
                    begin
                        led = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_LEDS - 1)
                                                          : $urandom_range(0, nleds - 1);
                        send_request(make_req(CMD_WRITE, led, COLOR_W'($urandom)));
                    end
                    send_request(make_req(CMD_START, 0, '0));
                    tick_through_frame(8);
                    repeat ($urandom_range(0, 2)) send_request(make_req(CMD_TICK, 0, '0));
                end
                else
                    send_request(random_req());
            end
            steady_mode = 1'b0;
            wait_for_results();
        end
    endtask

    always @(posedge clk)
    begin : result_sink
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_duty_q.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_CAP)
                    $display("%0t: unexpected result, expected none, actual duty %0d",
                             $time, result.duty);
            end
            else
            begin
                want = pending_duty_q.pop_front();
                compare_field("duty", 32'(want.duty), 32'(result.duty));
                compare_field("busy_res", 32'(want.busy_res), 32'(result.busy_res));
                compare_field("frame_done", 32'(want.frame_done), 32'(result.frame_done));
                compare_field("start_rejected", 32'(want.start_rejected),
                              32'(result.start_rejected));
            end
        end
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= steady_mode || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ws2812_bit_duty_serializer_top test failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_LEDS; i++)
            color_mem[LED_IDX_W'(i)] = '0;
        tx_led        = 0;
        tx_bit        = 0;
        tx_active     = 1'b0;
        led_count_reg = LED_COUNT_RST;
        high_duty_reg = HIGH_DUTY_RST;
        low_duty_reg  = LOW_DUTY_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_idle_requests();
        test_single_led_frame();
        test_mid_frame_changes();
        test_long_frame();
        test_back_pressure();
        test_random_frames();
        wait_for_results();

        if (error_count == 0)
            $display("ws2812_bit_duty_serializer_top test passed");
        else
            $display("ws2812_bit_duty_serializer_top test failed");
        $finish;
    end

endmodule
